FILE: sv/vertex_weld_table_macros.svh
// ---------------------------------------------------------------------------
// Vertex weld table assertion macros
// Concurrent assertion wrappers used by the controller of the block.
// ---------------------------------------------------------------------------
`ifndef VERTEX_WELD_TABLE_MACROS_SVH
`define VERTEX_WELD_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define VWT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex_weld_table: same-cycle check failed");
`define VWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex_weld_table: next-cycle check failed");
`else
`define VWT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define VWT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/vwt_pkg.sv
// ---------------------------------------------------------------------------
// Vertex weld table package
// Sizes, codes and the command and status types between control and datapath.
// ---------------------------------------------------------------------------
package vwt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int COORD_W     = 32;
   localparam int VTX_W       = 3 * COORD_W;
   localparam int OUT_IDX_W   = 6;
   localparam int OUT_CNT_W   = 7;
   localparam int STATUS_W    = 2;

   localparam logic [COORD_W-1:0] THRESHOLD_RESET = 32'd429497;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_MATCHED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd3;

   typedef struct packed {
      logic             load;
      logic             issue;
      logic             last;
      logic             flush;
      logic             write;
      logic [IDX_W-1:0] rd_addr;
      logic [IDX_W-1:0] wr_addr;
   } dp_cmd_type;

   typedef struct packed {
      logic             cmp_valid;
      logic             cmp_hit;
      logic             cmp_last;
      logic [IDX_W-1:0] cmp_idx;
   } dp_stat_type;

endpackage

FILE: sv/vwt_if.sv
// ---------------------------------------------------------------------------
// Vertex weld table channel interfaces
// Request, response and threshold write channels with valid/ready transfer.
// ---------------------------------------------------------------------------
interface vwt_req_if;
   import vwt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic signed [COORD_W-1:0] vertex_z;

   modport source (output valid, command, vertex_x, vertex_y, vertex_z, input ready);
   modport sink   (input valid, command, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface vwt_rsp_if;
   import vwt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] vertex_index;
   logic [STATUS_W-1:0]  status;
   logic [OUT_CNT_W-1:0] entry_count;

   modport source (output valid, vertex_index, status, entry_count, input ready);
   modport sink   (input valid, vertex_index, status, entry_count, output ready);
endinterface

interface vwt_csr_if;
   import vwt_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] match_threshold_sq;

   modport source (output valid, match_threshold_sq, input ready);
   modport sink   (input valid, match_threshold_sq, output ready);
endinterface

FILE: sv/vwt_datapath.sv
// ---------------------------------------------------------------------------
// Vertex weld table datapath
// Vertex store, threshold register and the pipelined squared-distance compare.
// ---------------------------------------------------------------------------
module vwt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  vwt_pkg::dp_cmd_type               cmd,
   output vwt_pkg::dp_stat_type              stat,
   input  logic signed [vwt_pkg::COORD_W-1:0] vertex_x,
   input  logic signed [vwt_pkg::COORD_W-1:0] vertex_y,
   input  logic signed [vwt_pkg::COORD_W-1:0] vertex_z,
   vwt_csr_if.sink                           csr_bus
);
   import vwt_pkg::*;

   localparam int SQ_W  = 2 * COORD_W;
   localparam int SUM_W = SQ_W + 2;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
      return m[COORD_W-1:0];
   endfunction

   logic [VTX_W-1:0]   mem [TABLE_DEPTH];

   logic [COORD_W-1:0] thr_ff;
   logic [COORD_W-1:0] vx_ff, vy_ff, vz_ff;

   logic               p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic               p1_last_ff, p2_last_ff, p3_last_ff, p4_last_ff;
   logic [IDX_W-1:0]   p1_idx_ff, p2_idx_ff, p3_idx_ff, p4_idx_ff;
   logic [VTX_W-1:0]   rd_data_ff;
   logic [COORD_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic [SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic               hit_ff;

   logic [SQ_W-1:0]    sq_x_in, sq_y_in, sq_z_in;
   logic [SUM_W-1:0]   sum_in;
   logic               hit_in;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_bus.valid) begin
         thr_ff <= csr_bus.match_threshold_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vx_ff <= vertex_x;
         vy_ff <= vertex_y;
         vz_ff <= vertex_z;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[cmd.wr_addr] <= {vx_ff, vy_ff, vz_ff};
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end

   assign sq_x_in = SQ_W'(mag_x_ff) * SQ_W'(mag_x_ff);
   assign sq_y_in = SQ_W'(mag_y_ff) * SQ_W'(mag_y_ff);
   assign sq_z_in = SQ_W'(mag_z_ff) * SQ_W'(mag_z_ff);

   // The exact sum is compared; saturation cannot change the outcome.
   assign sum_in = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   assign hit_in = sum_in < SUM_W'(thr_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.flush) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.issue;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_last_ff <= cmd.last;
      p1_idx_ff  <= cmd.rd_addr;
      p2_last_ff <= p1_last_ff;
      p2_idx_ff  <= p1_idx_ff;
      mag_x_ff   <= abs_diff(vx_ff, rd_data_ff[3*COORD_W-1:2*COORD_W]);
      mag_y_ff   <= abs_diff(vy_ff, rd_data_ff[2*COORD_W-1:COORD_W]);
      mag_z_ff   <= abs_diff(vz_ff, rd_data_ff[COORD_W-1:0]);
      p3_last_ff <= p2_last_ff;
      p3_idx_ff  <= p2_idx_ff;
      sq_x_ff    <= sq_x_in;
      sq_y_ff    <= sq_y_in;
      sq_z_ff    <= sq_z_in;
      p4_last_ff <= p3_last_ff;
      p4_idx_ff  <= p3_idx_ff;
      hit_ff     <= hit_in;
   end

   assign stat.cmp_valid = p4_valid_ff;
   assign stat.cmp_hit   = hit_ff;
   assign stat.cmp_last  = p4_last_ff;
   assign stat.cmp_idx   = p4_idx_ff;

endmodule

FILE: sv/vwt_ctrl.sv
// ---------------------------------------------------------------------------
// Vertex weld table controller
// Walks the stored vertices, decides match, add, full or clear, and holds
// the stored count and the response register.
// ---------------------------------------------------------------------------
`include "vertex_weld_table_macros.svh"

module vwt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   vwt_req_if.sink              req_bus,
   vwt_rsp_if.source            rsp_bus,
   output vwt_pkg::dp_cmd_type  cmd,
   input  vwt_pkg::dp_stat_type stat
);
   import vwt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     issue_ff, issue_in;
   logic                 issuing_ff, issuing_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;
   logic [OUT_IDX_W-1:0] rsp_idx_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [OUT_CNT_W-1:0] rsp_count_ff;
   logic                 req_fire;
   logic                 issue_last;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign issue_last    = (CNT_W'(issue_ff) == count_ff - CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      issuing_in    = issuing_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_load      = 1'b0;
      cmd           = '0;
      cmd.rd_addr   = issue_ff;
      cmd.wr_addr   = count_ff[IDX_W-1:0];
      cmd.last      = issue_last;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.command == CMD_CLEAR) begin
                  count_in      = '0;
                  res_idx_in    = '0;
                  res_status_in = STATUS_CLEARED;
                  state_in      = ST_DONE;
               end else begin
                  cmd.load   = 1'b1;
                  issue_in   = '0;
                  issuing_in = (count_ff != '0);
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = issuing_ff;
            if (issuing_ff) begin
               if (issue_last) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_in = issue_ff + IDX_W'(1);
               end
            end
            if (stat.cmp_valid && stat.cmp_hit) begin
               cmd.flush     = 1'b1;
               cmd.issue     = 1'b0;
               issuing_in    = 1'b0;
               res_idx_in    = stat.cmp_idx;
               res_status_in = STATUS_MATCHED;
               state_in      = ST_DONE;
            end else if ((stat.cmp_valid && stat.cmp_last) || count_ff == '0) begin
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  cmd.write     = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  res_idx_in    = count_ff[IDX_W-1:0];
                  res_status_in = STATUS_ADDED;
               end else begin
                  res_idx_in    = '0;
                  res_status_in = STATUS_FULL;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issuing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issuing_ff   <= issuing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_idx_ff    <= OUT_IDX_W'(res_idx_ff);
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= OUT_CNT_W'(count_ff);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.vertex_index = rsp_idx_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.entry_count  = rsp_count_ff;

   `VWT_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `VWT_ASSERT_IMPLIES(a_cmp_in_scan, clock, reset, stat.cmp_valid, state_ff == ST_SCAN)
   `VWT_ASSERT_IMPLIES(a_write_has_room, clock, reset, cmd.write, count_ff < CNT_W'(TABLE_DEPTH))
   `VWT_ASSERT_NEXT(a_clear_empties, clock, reset, req_fire && req_bus.command == CMD_CLEAR, count_ff == '0)

endmodule

FILE: sv/vertex_weld_table.sv
// ---------------------------------------------------------------------------
// Vertex weld table
// Welds Q16.16 vertices against a table of earlier vertices by squared
// distance threshold.
// ---------------------------------------------------------------------------
// One item is handled at a time. A lookup compares the vertex with the
// stored vertices in insertion order, one entry per cycle through a
// four-stage compare pipeline, and stops at the first match; when the
// vertex is added or the table is full, the whole count is compared. The
// scan rate is set by the single read port of the vertex store and the
// shared compare pipeline. A new request is taken as soon as the previous
// result sits in the response register, even if it waits there.
module vertex_weld_table (
   input logic       clock,
   input logic       reset,
   vwt_req_if.sink   req_bus,
   vwt_rsp_if.source rsp_bus,
   vwt_csr_if.sink   csr_bus
);
   import vwt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   vwt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .stat    (stat)
   );

   vwt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .vertex_x (req_bus.vertex_x),
      .vertex_y (req_bus.vertex_y),
      .vertex_z (req_bus.vertex_z),
      .csr_bus  (csr_bus)
   );

endmodule
